// ----- rtl/table_linear_interpolator_defines.svh -----
// assertion macros for the breakpoint interpolator
`ifndef TABLE_LINEAR_INTERPOLATOR_DEFINES_SVH
`define TABLE_LINEAR_INTERPOLATOR_DEFINES_SVH

`ifndef SYNTH
// property holds at every edge out of reset
`define TLI_ASSERT(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// condition in one cycle implies a condition in the next
`define TLI_ASSERT_NEXT(lbl, clk, rst_n, pre, post, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) else $error(msg);
`else
`define TLI_ASSERT(lbl, clk, rst_n, prop, msg)
`define TLI_ASSERT_NEXT(lbl, clk, rst_n, pre, post, msg)
`endif

`endif

// ----- rtl/tli_pkg.sv -----
package tli_pkg;

	localparam int TABLE_DEPTH = 64;
	localparam int FRAC_BITS   = 16;
	localparam int IDX_W       = $clog2(TABLE_DEPTH);
	localparam int CNT_W       = IDX_W + 1;
	localparam int DATA_W      = 32;

	// command codes
	localparam logic [1:0] CMD_CLEAR = 2'd0;
	localparam logic [1:0] CMD_LOAD  = 2'd1;
	localparam logic [1:0] CMD_QUERY = 2'd2;

	// status codes
	localparam logic [2:0] STS_HIT     = 3'd0;
	localparam logic [2:0] STS_INTERP  = 3'd1;
	localparam logic [2:0] STS_RANGE   = 3'd2;
	localparam logic [2:0] STS_EMPTY   = 3'd3;
	localparam logic [2:0] STS_LOADED  = 3'd4;
	localparam logic [2:0] STS_FULL    = 3'd5;
	localparam logic [2:0] STS_CLEARED = 3'd6;

	typedef logic signed [DATA_W-1:0] q16_t;

	typedef struct packed {
		q16_t value;
		q16_t key;
	} entry_t;

endpackage

// ----- rtl/tli_divider.sv -----
module tli_divider (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           start,
	input  logic [2*tli_pkg::DATA_W-1:0]   num,
	input  logic [tli_pkg::DATA_W-1:0]     den,
	output logic                           busy,
	output logic                           done,
	output logic [tli_pkg::DATA_W-1:0]     quo
);
	import tli_pkg::*;

	localparam int STEP_W = $clog2(DATA_W);

	// quotient is known to fit in DATA_W bits, so the high half of num is below den
	logic [DATA_W-1:0] rem_q;
	logic [DATA_W-1:0] low_q;
	logic [STEP_W-1:0] step_q;
	logic              busy_q;
	logic              done_q;
	logic [DATA_W:0]   shifted;
	logic [DATA_W:0]   trial;

	assign shifted = {rem_q, low_q[DATA_W-1]};
	assign trial   = shifted - {1'b0, den};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				step_q <= '0;
			end else if (busy_q) begin
				step_q <= step_q + STEP_W'(1);
				if (step_q == STEP_W'(DATA_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= num[2*DATA_W-1:DATA_W];
			low_q <= num[DATA_W-1:0];
		end else if (busy_q) begin
			if (!trial[DATA_W]) begin
				rem_q <= trial[DATA_W-1:0];
				low_q <= {low_q[DATA_W-2:0], 1'b1};
			end else begin
				rem_q <= shifted[DATA_W-1:0];
				low_q <= {low_q[DATA_W-2:0], 1'b0};
			end
		end
	end

	assign busy = busy_q;
	assign done = done_q;
	assign quo  = low_q;

endmodule

// ----- rtl/table_linear_interpolator.sv -----
// piecewise linear lookup over a sorted table of signed Q16.16 breakpoints
//
// input channel s_*: s_tuser carries the command (clear, load, query); s_tdata
// carries key and value. output channel m_*: m_tuser carries the status,
// m_tdata the result value and the number of entries now held.
// every command gives exactly one result item; the unused command code is
// taken and dropped without a result.
// one item is worked on at a time; s_tready is high only when the engine idles.
// the table lives in one synchronous memory of key/value pairs, one read and
// one write per cycle, so each command's steps follow the memory port:
//   clear: straight to the output register
//   load : straight to the output register for an empty or full table, else
//          a scan down from the top, shifting larger entries up to open the slot
//   query: a scan up from zero, then the multiply and the 32-step
//          restoring divider when the key falls between breakpoints
// reset empties the table at once (count to zero); no clearing pass is needed.
// a finished result sits in the output register; a stalled receiver holds the
// engine in its emit step, so the next item waits until the result is taken.
module table_linear_interpolator (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [63:0] s_tdata,   // key [31:0], value [63:32]
	input  logic [1:0]  s_tuser,   // command [1:0]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [39:0] m_tdata,   // result [31:0], entries [38:32], zero pad [39]
	output logic [2:0]  m_tuser    // status [2:0]
);
	import tli_pkg::*;

	`include "table_linear_interpolator_defines.svh"

	// engine states
	localparam logic [3:0] S_IDLE   = 4'd0;
	localparam logic [3:0] S_LSCAN  = 4'd1;
	localparam logic [3:0] S_LINS   = 4'd2;
	localparam logic [3:0] S_QSCAN  = 4'd3;
	localparam logic [3:0] S_QMUL   = 4'd4;
	localparam logic [3:0] S_QSTART = 4'd5;
	localparam logic [3:0] S_QDIV   = 4'd6;
	localparam logic [3:0] S_EMIT   = 4'd7;

	logic [3:0]         state_q;
	logic [CNT_W-1:0]   cnt_q;
	logic [IDX_W-1:0]   ptr_q;
	q16_t               key_q;
	q16_t               val_q;
	q16_t               prev_key_q;
	q16_t               prev_val_q;
	logic [2:0]         sts_q;
	q16_t               res_q;

	// interpolation operands
	logic [DATA_W-1:0]   dq_q;
	logic [DATA_W-1:0]   dk_q;
	logic [DATA_W-1:0]   mag_q;
	logic                neg_q;
	logic [2*DATA_W-1:0] prod_q;

	// output register
	logic               out_valid_q;
	logic [2:0]         out_sts_q;
	q16_t               out_res_q;
	logic [CNT_W-1:0]   out_cnt_q;

	// table memory
	entry_t             mem [TABLE_DEPTH];
	entry_t             rd_q;
	logic [IDX_W-1:0]   rd_addr;
	logic               we;
	logic [IDX_W-1:0]   wr_addr;
	entry_t             wr_data;

	logic               in_fire;
	logic [1:0]         in_cmd;
	q16_t               in_key;
	q16_t               in_val;
	logic [CNT_W-1:0]   cnt_m1;
	logic [CNT_W-1:0]   ptr_p1;
	logic               at_last;
	logic               out_free;

	logic [DATA_W:0]    dq_w;
	logic [DATA_W:0]    dk_w;
	logic [DATA_W:0]    dv_w;
	logic [DATA_W:0]    mag_w;

	logic               div_start;
	logic               div_busy;
	logic               div_done;
	logic [DATA_W-1:0]  div_quo;

	assign in_cmd   = s_tuser;
	assign in_key   = s_tdata[31:0];
	assign in_val   = s_tdata[63:32];
	assign s_tready = (state_q == S_IDLE);
	assign in_fire  = s_tvalid && s_tready;
	assign out_free = !out_valid_q || m_tready;

	assign cnt_m1  = cnt_q - CNT_W'(1);
	assign ptr_p1  = {1'b0, ptr_q} + CNT_W'(1);
	assign at_last = (ptr_p1 == cnt_q);

	// differences against the lower breakpoint, taken at the interval boundary
	assign dq_w  = {key_q[DATA_W-1], key_q} - {prev_key_q[DATA_W-1], prev_key_q};
	assign dk_w  = {rd_q.key[DATA_W-1], rd_q.key} - {prev_key_q[DATA_W-1], prev_key_q};
	assign dv_w  = {rd_q.value[DATA_W-1], rd_q.value} - {prev_val_q[DATA_W-1], prev_val_q};
	assign mag_w = dv_w[DATA_W] ? (~dv_w + (DATA_W+1)'(1)) : dv_w;

	// read address: loads walk down from the top, queries walk up from zero
	always_comb begin
		rd_addr = '0;
		case (state_q)
			S_IDLE:  rd_addr = (in_cmd == CMD_LOAD) ? cnt_m1[IDX_W-1:0] : '0;
			S_LSCAN: rd_addr = ptr_q - IDX_W'(1);
			S_QSCAN: rd_addr = ptr_p1[IDX_W-1:0];
			default: rd_addr = '0;
		endcase
	end

	// write port: move an entry up one slot or drop in the new pair
	always_comb begin
		we      = 1'b0;
		wr_addr = '0;
		wr_data = '{value: val_q, key: key_q};
		case (state_q)
			S_IDLE: begin
				if (in_fire && in_cmd == CMD_LOAD && cnt_q == '0) begin
					we      = 1'b1;
					wr_data = '{value: in_val, key: in_key};
				end
			end
			S_LSCAN: begin
				we      = 1'b1;
				wr_addr = ptr_p1[IDX_W-1:0];
				if (rd_q.key > key_q)
					wr_data = rd_q;
			end
			S_LINS: begin
				we = 1'b1;
			end
			default: we = 1'b0;
		endcase
	end

	always_ff @(posedge clk) begin
		if (we)
			mem[wr_addr] <= wr_data;
		rd_q <= mem[rd_addr];
	end

	assign div_start = (state_q == S_QSTART);

	tli_divider u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (prod_q),
		.den    (dk_q),
		.busy   (div_busy),
		.done   (div_done),
		.quo    (div_quo)
	);

	// control engine
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			cnt_q   <= '0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (in_fire) begin
						case (in_cmd)
							CMD_CLEAR: begin
								cnt_q   <= '0;
								state_q <= S_EMIT;
							end
							CMD_LOAD: begin
								if (cnt_q == CNT_W'(TABLE_DEPTH)) begin
									state_q <= S_EMIT;
								end else if (cnt_q == '0) begin
									cnt_q   <= CNT_W'(1);
									state_q <= S_EMIT;
								end else begin
									state_q <= S_LSCAN;
								end
							end
							CMD_QUERY: begin
								state_q <= (cnt_q == '0) ? S_EMIT : S_QSCAN;
							end
							default: state_q <= S_IDLE;
						endcase
					end
				end
				S_LSCAN: begin
					if (rd_q.key > key_q) begin
						if (ptr_q == '0)
							state_q <= S_LINS;
					end else begin
						cnt_q   <= cnt_q + CNT_W'(1);
						state_q <= S_EMIT;
					end
				end
				S_LINS: begin
					cnt_q   <= cnt_q + CNT_W'(1);
					state_q <= S_EMIT;
				end
				S_QSCAN: begin
					if (rd_q.key == key_q)
						state_q <= S_EMIT;
					else if (rd_q.key > key_q)
						state_q <= (ptr_q == '0) ? S_EMIT : S_QMUL;
					else if (at_last)
						state_q <= S_EMIT;
				end
				S_QMUL:   state_q <= S_QSTART;
				S_QSTART: state_q <= S_QDIV;
				S_QDIV: begin
					if (div_done)
						state_q <= S_EMIT;
				end
				S_EMIT: begin
					if (out_free)
						state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// working registers of the engine
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				key_q <= in_key;
				val_q <= in_val;
				res_q <= '0;
				ptr_q <= (in_cmd == CMD_LOAD) ? cnt_m1[IDX_W-1:0] : '0;
				case (in_cmd)
					CMD_CLEAR: sts_q <= STS_CLEARED;
					CMD_LOAD:  sts_q <= (cnt_q == CNT_W'(TABLE_DEPTH)) ? STS_FULL : STS_LOADED;
					default:   sts_q <= STS_EMPTY;
				endcase
			end
			S_LSCAN: begin
				ptr_q <= ptr_q - IDX_W'(1);
			end
			S_QSCAN: begin
				if (rd_q.key == key_q) begin
					sts_q <= STS_HIT;
					res_q <= rd_q.value;
				end else if (rd_q.key > key_q) begin
					sts_q <= (ptr_q == '0) ? STS_RANGE : STS_INTERP;
					dq_q  <= dq_w[DATA_W-1:0];
					dk_q  <= dk_w[DATA_W-1:0];
					mag_q <= mag_w[DATA_W-1:0];
					neg_q <= dv_w[DATA_W];
				end else if (at_last) begin
					sts_q <= STS_RANGE;
				end else begin
					prev_key_q <= rd_q.key;
					prev_val_q <= rd_q.value;
					ptr_q      <= ptr_q + IDX_W'(1);
				end
			end
			S_QMUL: begin
				prod_q <= dq_q * mag_q;
			end
			S_QDIV: begin
				if (div_done)
					res_q <= neg_q ? (prev_val_q - div_quo) : (prev_val_q + div_quo);
			end
			default: ;
		endcase
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == S_EMIT && out_free) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_EMIT && out_free) begin
			out_sts_q <= sts_q;
			out_res_q <= res_q;
			out_cnt_q <= cnt_q;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tuser  = out_sts_q;
	assign m_tdata  = {1'b0, out_cnt_q, out_res_q};

	`TLI_ASSERT(a_cnt_bound, clk, arst_n, cnt_q <= CNT_W'(TABLE_DEPTH), "entry count above table depth")
	`TLI_ASSERT(a_write_in_load, clk, arst_n, !we || state_q == S_IDLE || state_q == S_LSCAN || state_q == S_LINS, "table written outside a load")
	`TLI_ASSERT(a_div_owner, clk, arst_n, !div_busy || state_q == S_QDIV, "divider busy outside the divide step")
	`TLI_ASSERT(a_zero_miss, clk, arst_n, !m_tvalid || m_tuser == STS_HIT || m_tuser == STS_INTERP || m_tdata[31:0] == '0, "nonzero result without a hit")
	`TLI_ASSERT_NEXT(a_load_grows, clk, arst_n, state_q == S_LINS, cnt_q == $past(cnt_q) + CNT_W'(1) && state_q == S_EMIT, "insert at slot zero did not grow the table")

endmodule
